FILE: sv/cfla_pkg.sv
package cfla_pkg;

   localparam int SLOT_W     = 6;
   localparam int LINK_W     = SLOT_W + 1;
   localparam int SLOT_COUNT = 1 << SLOT_W;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_OOM  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FILL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic acc_free;   // accepted free: push slot
      logic acc_pop;    // accepted allocate with a non-empty list
      logic acc_chunk;  // accepted allocate that opens a new chunk
      logic acc_fail;   // accepted allocate with nothing left
      logic ld_link;    // load the new head from the link memory
      logic fill_step;  // write one link of the chunk being opened
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic head_valid;
      logic chunk_avail;
      logic fill_last;
      logic out_full;
   } status_type;

endpackage

FILE: sv/cfla_ram.sv
module cfla_ram
   #(
      parameter int WIDTH = 7,
      parameter int DEPTH = 64
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/cfla_ctrl.sv
module cfla_ctrl
   import cfla_pkg::*;
   (
      input  logic       clock,
      input  logic       reset,
      input  logic       req_tvalid,
      input  logic       req_type,
      input  logic       rsp_tready,
      input  status_type status,
      output logic       req_tready,
      output cmd_type    cmd
   );

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      accept     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // The result register must be free, or emptying, when the beat lands.
            req_tready = !status.out_full || rsp_tready;
            accept     = req_tvalid && req_tready;
            if (accept) begin
               if (req_type == REQ_FREE) begin
                  cmd.acc_free = 1'b1;
               end else if (status.head_valid) begin
                  cmd.acc_pop = 1'b1;
                  state_in    = ST_READ;
               end else if (status.chunk_avail) begin
                  cmd.acc_chunk = 1'b1;
                  state_in      = ST_FILL;
               end else begin
                  cmd.acc_fail = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.ld_link = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   property p_read_one_cycle;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_READ) |=> (state_ff == ST_IDLE);
   endproperty
   a_read_one_cycle: assert property (p_read_one_cycle)
      else $error("link load state lasted more than one cycle");

   property p_fill_exit;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_FILL && status.fill_last) |=> (state_ff == ST_IDLE);
   endproperty
   a_fill_exit: assert property (p_fill_exit)
      else $error("chunk fill did not end after its last link");

   property p_busy_blocks_input;
      @(posedge clock) disable iff (reset)
         (state_ff != ST_IDLE) |-> !req_tready;
   endproperty
   a_busy_blocks_input: assert property (p_busy_blocks_input)
      else $error("request taken while a link load or chunk fill was running");

endmodule

FILE: sv/cfla_dp.sv
module cfla_dp
   import cfla_pkg::*;
   #(
      parameter int CHUNK_SLOTS = 4,
      parameter int MAX_CHUNKS  = 16
   )
   (
      input  logic              clock,
      input  logic              reset,
      input  cmd_type           cmd,
      input  logic [SLOT_W-1:0] slot_in,
      input  logic              rsp_tready,
      output status_type        status,
      output logic              out_valid,
      output logic [SLOT_W-1:0] out_slot,
      output logic              out_status
   );

   localparam int FIT     = SLOT_COUNT / CHUNK_SLOTS;
   localparam int LIMIT   = (MAX_CHUNKS < FIT) ? MAX_CHUNKS : FIT;
   localparam int CW      = $clog2(LIMIT + 1);
   localparam int FCW     = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
   localparam int PW      = CW + SLOT_W + 1;

   logic [SLOT_W-1:0] head_slot_ff, head_slot_in;
   logic              head_valid_ff, head_valid_in;
   logic [CW-1:0]     chunks_used_ff, chunks_used_in;
   logic [SLOT_W-1:0] fill_base_ff, fill_base_in;
   logic [FCW-1:0]    fill_cnt_ff, fill_cnt_in;
   logic              out_valid_ff, out_valid_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic              out_status_ff, out_status_in;

   logic [PW-1:0]     base_wide;
   logic [SLOT_W-1:0] base;
   logic              chunk_avail;
   logic              fill_last;
   logic [SLOT_W-1:0] fill_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [LINK_W-1:0] wr_data;
   logic [LINK_W-1:0] rd_data;

   assign base_wide   = PW'(chunks_used_ff) * PW'(CHUNK_SLOTS);
   assign base        = base_wide[SLOT_W-1:0];
   assign chunk_avail = chunks_used_ff < CW'(LIMIT);
   assign fill_last   = fill_cnt_ff == FCW'(CHUNK_SLOTS - 1);
   assign fill_addr   = fill_base_ff + SLOT_W'(fill_cnt_ff);

   // The memory takes a free's push or one link of a chunk being opened.
   always_comb begin
      wr_en   = cmd.acc_free || cmd.fill_step;
      wr_addr = fill_addr;
      wr_data = fill_last ? '0 : {1'b1, fill_addr + SLOT_W'(1)};
      if (cmd.acc_free) begin
         wr_addr = slot_in;
         wr_data = {head_valid_ff, head_slot_ff};
      end
   end

   cfla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (SLOT_COUNT)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (head_slot_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      head_slot_in   = head_slot_ff;
      head_valid_in  = head_valid_ff;
      chunks_used_in = chunks_used_ff;
      fill_base_in   = fill_base_ff;
      fill_cnt_in    = fill_cnt_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_slot_in    = out_slot_ff;
      out_status_in  = out_status_ff;

      if (cmd.acc_free) begin
         head_slot_in  = slot_in;
         head_valid_in = 1'b1;
         out_valid_in  = 1'b1;
         out_slot_in   = slot_in;
         out_status_in = STAT_OK;
      end
      if (cmd.acc_pop) begin
         out_valid_in  = 1'b1;
         out_slot_in   = head_slot_ff;
         out_status_in = STAT_OK;
      end
      if (cmd.acc_chunk) begin
         // The first slot of the chunk goes out at once; the rest form the list.
         head_slot_in   = base + SLOT_W'(1);
         head_valid_in  = CHUNK_SLOTS > 1;
         chunks_used_in = chunks_used_ff + CW'(1);
         fill_base_in   = base;
         fill_cnt_in    = '0;
         out_valid_in   = 1'b1;
         out_slot_in    = base;
         out_status_in  = STAT_OK;
      end
      if (cmd.acc_fail) begin
         out_valid_in  = 1'b1;
         out_slot_in   = '0;
         out_status_in = STAT_OOM;
      end
      if (cmd.ld_link) begin
         head_slot_in  = rd_data[SLOT_W-1:0];
         head_valid_in = rd_data[LINK_W-1];
      end
      if (cmd.fill_step && !fill_last) begin
         fill_cnt_in = fill_cnt_ff + FCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_slot_ff   <= '0;
         head_valid_ff  <= 1'b0;
         chunks_used_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         head_slot_ff   <= head_slot_in;
         head_valid_ff  <= head_valid_in;
         chunks_used_ff <= chunks_used_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_base_ff  <= fill_base_in;
      fill_cnt_ff   <= fill_cnt_in;
      out_slot_ff   <= out_slot_in;
      out_status_ff <= out_status_in;
   end

   assign status.head_valid  = head_valid_ff;
   assign status.chunk_avail = chunk_avail;
   assign status.fill_last   = fill_last;
   assign status.out_full    = out_valid_ff;
   assign out_valid          = out_valid_ff;
   assign out_slot           = out_slot_ff;
   assign out_status         = out_status_ff;

   property p_pop_needs_head;
      @(posedge clock) disable iff (reset)
         cmd.acc_pop |-> head_valid_ff;
   endproperty
   a_pop_needs_head: assert property (p_pop_needs_head)
      else $error("pop issued on an empty free list");

   property p_chunk_needs_room;
      @(posedge clock) disable iff (reset)
         cmd.acc_chunk |-> (!head_valid_ff && chunk_avail);
   endproperty
   a_chunk_needs_room: assert property (p_chunk_needs_room)
      else $error("chunk opened while the list was non-empty or no chunk was left");

   property p_oom_slot_zero;
      @(posedge clock) disable iff (reset)
         (out_valid_ff && out_status_ff == STAT_OOM) |-> (out_slot_ff == '0);
   endproperty
   a_oom_slot_zero: assert property (p_oom_slot_zero)
      else $error("out-of-memory result carries a nonzero slot");

   property p_free_sets_head;
      @(posedge clock) disable iff (reset)
         cmd.acc_free |=> (head_valid_ff && head_slot_ff == $past(slot_in));
   endproperty
   a_free_sets_head: assert property (p_free_sets_head)
      else $error("freed slot did not become the list head");

endmodule

FILE: sv/chunked_free_list_allocator_top.sv
// Chunked free-list slot allocator.
// The request channel (req_) carries one beat per operation: req_tuser[0] selects
// allocate (0) or free (1), and req_tdata[5:0] holds the slot handle to free.
// The response channel (rsp_) returns exactly one beat per request: rsp_tdata[5:0]
// holds the allocated handle or the echoed freed handle, and rsp_tuser[0] is set
// when an allocate finds no free slot and no unopened chunk (the handle is then 0).
// Free slots form a last-in first-out list linked through a 64-entry link memory
// with a registered read port; slots are opened CHUNK_SLOTS at a time.
// Every response lands in the response register in the cycle after its request beat.
// A free or a failed allocate leaves the controller idle. An allocate from a
// non-empty list passes through ST_READ, because the new head comes out of the
// link memory's registered read port. An allocate that opens a chunk passes
// through ST_FILL, which writes the chunk's links into the memory one by one.
// A synchronous reset empties the list and marks every chunk unopened; the link
// memory is not cleared, since an entry is always written before it is read.
// The response register holds one beat; a new request is taken while it still
// waits only if rsp_tready drains it in that same cycle, so a stalled receiver
// holds off every further request until the waiting response drains.
module chunked_free_list_allocator_top
   import cfla_pkg::*;
   #(
      parameter int CHUNK_SLOTS = 4,
      parameter int MAX_CHUNKS  = 16
   )
   (
      input  logic       clock,
      input  logic       reset,
      input  logic       req_tvalid,
      output logic       req_tready,
      input  logic [7:0] req_tdata,   // [5:0] slot_in, [7:6] zero
      input  logic [0:0] req_tuser,   // [0] req_type
      output logic       rsp_tvalid,
      input  logic       rsp_tready,
      output logic [7:0] rsp_tdata,   // [5:0] slot_out, [7:6] zero
      output logic [0:0] rsp_tuser    // [0] status
   );

   cmd_type           cmd;
   status_type        status;
   logic [SLOT_W-1:0] out_slot;
   logic              out_status;

   cfla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser[0]),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   cfla_dp #(
      .CHUNK_SLOTS (CHUNK_SLOTS),
      .MAX_CHUNKS  (MAX_CHUNKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .slot_in    (req_tdata[SLOT_W-1:0]),
      .rsp_tready (rsp_tready),
      .status     (status),
      .out_valid  (rsp_tvalid),
      .out_slot   (out_slot),
      .out_status (out_status)
   );

   // The handle sits in the low bits; the upper bits of the byte stay zero.
   assign rsp_tdata    = {{(8 - SLOT_W){1'b0}}, out_slot};
   assign rsp_tuser[0] = out_status;

endmodule
